[rtl/gmpw_pkg.sv]
// Package for the glyph mask pixel writer: widths, register codes, config struct,
// pipeline stage struct and the pixel format helpers. No dependencies.
`default_nettype none

package gmpw_pkg;

  localparam int MAX_DIM = 2048;
  localparam int CFG_W   = 12;
  localparam int DIM_W   = $clog2(MAX_DIM);
  localparam int CMP_W   = (DIM_W + 1 > CFG_W) ? DIM_W + 1 : CFG_W;
  localparam int POS_W   = CMP_W + 1;
  localparam int OFS_W   = 24;
  localparam int PIX_W   = 32;
  localparam int BYTES_W = 3;
  localparam int COV_W   = 8;
  localparam int IDX_W   = 3;

  typedef enum logic [IDX_W-1:0] {
    CFG_ORIGIN_X     = 3'd0,
    CFG_ORIGIN_Y     = 3'd1,
    CFG_GLYPH_WIDTH  = 3'd2,
    CFG_GLYPH_HEIGHT = 3'd3,
    CFG_SCREEN_WIDTH = 3'd4,
    CFG_SCREEN_HEIGHT= 3'd5,
    CFG_PIXEL_MODE   = 3'd6,
    CFG_DRAW_COLOR   = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PIX_8BPP  = 2'd0,
    PIX_565   = 2'd1,
    PIX_32BPP = 2'd2,
    PIX_NONE  = 2'd3
  } pix_mode_e;

  typedef struct packed {
    logic signed [CFG_W-1:0] origin_x;
    logic signed [CFG_W-1:0] origin_y;
    logic [CFG_W-1:0]        glyph_width;
    logic [CFG_W-1:0]        glyph_height;
    logic [CFG_W-1:0]        screen_width;
    logic [CFG_W-1:0]        screen_height;
    pix_mode_e               pixel_mode;
    logic [PIX_W-1:0]        draw_color;
  } cfg_t;

  typedef struct packed {
    logic                    valid;
    logic                    draw;
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
  } stg_t;

  localparam logic [CFG_W-1:0] RST_GLYPH_W  = CFG_W'(1);
  localparam logic [CFG_W-1:0] RST_GLYPH_H  = CFG_W'(1);
  localparam logic [CFG_W-1:0] RST_SCREEN_W = CFG_W'(800);
  localparam logic [CFG_W-1:0] RST_SCREEN_H = CFG_W'(480);

  // glyph dimension as used by the counters: zero acts as one, clamp at MAX_DIM
  function automatic logic [CMP_W-1:0] eff_dim(input logic [CFG_W-1:0] v);
    logic [CMP_W-1:0] r;
    if (v == '0) begin
      r = CMP_W'(1);
    end else if (int'(v) > MAX_DIM) begin
      r = CMP_W'(MAX_DIM);
    end else begin
      r = CMP_W'(v);
    end
    return r;
  endfunction

  function automatic logic [PIX_W-1:0] rgb565(input logic [PIX_W-1:0] c);
    return {16'h0, c[23:19], c[15:10], c[7:3]};
  endfunction

endpackage

`default_nettype wire

[rtl/gmpw_if.sv]
// Channel interfaces of the glyph mask pixel writer: mask input, pixel write output
// and register write port. Depends on gmpw_pkg.
`default_nettype none

interface gmpw_in_if import gmpw_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [COV_W-1:0] coverage;
  logic             glyph_start;

  modport source (output valid, coverage, glyph_start, input ready);
  modport sink   (input valid, coverage, glyph_start, output ready);
endinterface

interface gmpw_out_if import gmpw_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [OFS_W-1:0]   byte_offset;
  logic [PIX_W-1:0]   pixel_value;
  logic [BYTES_W-1:0] write_bytes;

  modport source (output valid, byte_offset, pixel_value, write_bytes, input ready);
  modport sink   (input valid, byte_offset, pixel_value, write_bytes, output ready);
endinterface

interface gmpw_cfg_if import gmpw_pkg::*; ();
  logic             valid;
  logic             ready;
  cfg_idx_e         index;
  logic [PIX_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[rtl/gmpw_cfg_regs.sv]
// Register file for the glyph mask pixel writer configuration.
// Depends on gmpw_pkg and gmpw_cfg_if.
`default_nettype none

module gmpw_cfg_regs import gmpw_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  gmpw_cfg_if.sink    cfg_i,
  output cfg_t        cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_ORIGIN_X:      cfg_d.origin_x      = cfg_i.data[CFG_W-1:0];
        CFG_ORIGIN_Y:      cfg_d.origin_y      = cfg_i.data[CFG_W-1:0];
        CFG_GLYPH_WIDTH:   cfg_d.glyph_width   = cfg_i.data[CFG_W-1:0];
        CFG_GLYPH_HEIGHT:  cfg_d.glyph_height  = cfg_i.data[CFG_W-1:0];
        CFG_SCREEN_WIDTH:  cfg_d.screen_width  = cfg_i.data[CFG_W-1:0];
        CFG_SCREEN_HEIGHT: cfg_d.screen_height = cfg_i.data[CFG_W-1:0];
        CFG_PIXEL_MODE:    cfg_d.pixel_mode    = pix_mode_e'(cfg_i.data[1:0]);
        CFG_DRAW_COLOR:    cfg_d.draw_color    = cfg_i.data;
        default:           cfg_d               = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.origin_x      <= '0;
      cfg_q.origin_y      <= '0;
      cfg_q.glyph_width   <= RST_GLYPH_W;
      cfg_q.glyph_height  <= RST_GLYPH_H;
      cfg_q.screen_width  <= RST_SCREEN_W;
      cfg_q.screen_height <= RST_SCREEN_H;
      cfg_q.pixel_mode    <= PIX_565;
      cfg_q.draw_color    <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

[rtl/gmpw_walker.sv]
// Mask walker: column/row counters and the input stage register holding the
// screen position of each accepted mask byte. Depends on gmpw_pkg and gmpw_in_if.
`default_nettype none

module gmpw_walker import gmpw_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  cfg_t       cfg_i,
  gmpw_in_if.sink    mask_i,
  input  wire logic  stg_ready_i,
  output stg_t       stg_o
);

  logic [DIM_W-1:0]        col_q, col_d;
  logic [DIM_W-1:0]        row_q, row_d;
  logic                    valid_q, valid_d;
  logic                    draw_q, draw_d;
  logic signed [POS_W-1:0] x_q, x_d;
  logic signed [POS_W-1:0] y_q, y_d;

  logic                    stage_ready;
  logic                    accept;
  logic [DIM_W-1:0]        col_cur, row_cur;
  logic [CMP_W-1:0]        col_inc, row_inc;
  logic [CMP_W-1:0]        gw, gh;
  logic signed [POS_W-1:0] org_x_ext, org_y_ext;

  assign stage_ready  = !valid_q || stg_ready_i;
  assign mask_i.ready = stage_ready;
  assign accept       = mask_i.valid && stage_ready;

  assign gw        = eff_dim(cfg_i.glyph_width);
  assign gh        = eff_dim(cfg_i.glyph_height);
  assign org_x_ext = POS_W'(cfg_i.origin_x);
  assign org_y_ext = POS_W'(cfg_i.origin_y);

  always_comb begin
    col_cur = mask_i.glyph_start ? '0 : col_q;
    row_cur = mask_i.glyph_start ? '0 : row_q;
    col_inc = CMP_W'(col_cur) + CMP_W'(1);
    row_inc = CMP_W'(row_cur) + CMP_W'(1);

    col_d   = col_q;
    row_d   = row_q;
    valid_d = valid_q;
    draw_d  = draw_q;
    x_d     = x_q;
    y_d     = y_q;

    if (stage_ready) begin
      valid_d = mask_i.valid;
    end
    if (accept) begin
      draw_d = mask_i.coverage != '0;
      x_d    = org_x_ext + $signed({1'b0, (POS_W-1)'(col_cur)});
      y_d    = org_y_ext + $signed({1'b0, (POS_W-1)'(row_cur)});
      if (col_inc >= gw) begin
        col_d = '0;
        row_d = (row_inc >= gh) ? '0 : row_inc[DIM_W-1:0];
      end else begin
        col_d = col_inc[DIM_W-1:0];
        row_d = row_cur;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    draw_q <= draw_d;
    x_q    <= x_d;
    y_q    <= y_d;
  end

  assign stg_o.valid = valid_q;
  assign stg_o.draw  = draw_q;
  assign stg_o.x     = x_q;
  assign stg_o.y     = y_q;

  a_start_at_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && mask_i.glyph_start |=> x_q == $past(org_x_ext) && y_q == $past(org_y_ext))
    else $error("glyph start did not place pixel at origin");

  a_stage_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(valid_q) |-> $past(stg_ready_i))
    else $error("stage dropped a transaction");

  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !stg_ready_i |=> valid_q && $stable(x_q) && $stable(y_q) && $stable(draw_q))
    else $error("stalled stage changed");

endmodule

`default_nettype wire

[rtl/gmpw_pixel_gen.sv]
// Pixel generator: clipping, offset multiply, color conversion and the output
// register. Depends on gmpw_pkg and gmpw_out_if.
`default_nettype none

module gmpw_pixel_gen import gmpw_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  cfg_t       cfg_i,
  input  stg_t       stg_i,
  output logic       stg_ready_o,
  gmpw_out_if.source wr_o
);

  logic               valid_q, valid_d;
  logic [OFS_W-1:0]   offset_q, offset_d;
  logic [PIX_W-1:0]   value_q, value_d;
  logic [BYTES_W-1:0] bytes_q, bytes_d;

  logic               on_screen;
  logic               hit;
  logic [CFG_W-1:0]   x12, y12;
  logic [2*CFG_W-1:0] prod;
  logic [OFS_W-1:0]   pix_idx;
  logic [OFS_W-1:0]   ofs_mode;
  logic [PIX_W-1:0]   val_mode;
  logic [BYTES_W-1:0] bytes_mode;

  assign stg_ready_o = !valid_q || wr_o.ready;

  assign x12 = stg_i.x[CFG_W-1:0];
  assign y12 = stg_i.y[CFG_W-1:0];

  assign on_screen = !stg_i.x[POS_W-1] && !stg_i.y[POS_W-1]
                   && (stg_i.x < $signed({1'b0, (POS_W-1)'(cfg_i.screen_width)}))
                   && (stg_i.y < $signed({1'b0, (POS_W-1)'(cfg_i.screen_height)}));
  assign hit = stg_i.draw && on_screen && (cfg_i.pixel_mode != PIX_NONE);

  assign prod    = y12 * cfg_i.screen_width;
  assign pix_idx = OFS_W'(prod) + OFS_W'(x12);

  always_comb begin
    unique case (cfg_i.pixel_mode)
      PIX_8BPP: begin
        ofs_mode   = pix_idx;
        val_mode   = {24'h0, cfg_i.draw_color[7:0]};
        bytes_mode = BYTES_W'(1);
      end
      PIX_565: begin
        ofs_mode   = {pix_idx[OFS_W-2:0], 1'b0};
        val_mode   = rgb565(cfg_i.draw_color);
        bytes_mode = BYTES_W'(2);
      end
      PIX_32BPP: begin
        ofs_mode   = {pix_idx[OFS_W-3:0], 2'b00};
        val_mode   = cfg_i.draw_color;
        bytes_mode = BYTES_W'(4);
      end
      default: begin
        ofs_mode   = '0;
        val_mode   = '0;
        bytes_mode = '0;
      end
    endcase
  end

  always_comb begin
    valid_d  = valid_q;
    offset_d = offset_q;
    value_d  = value_q;
    bytes_d  = bytes_q;
    if (stg_ready_o) begin
      valid_d = stg_i.valid && hit;
      if (stg_i.valid && hit) begin
        offset_d = ofs_mode;
        value_d  = val_mode;
        bytes_d  = bytes_mode;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    offset_q <= offset_d;
    value_q  <= value_d;
    bytes_q  <= bytes_d;
  end

  assign wr_o.valid       = valid_q;
  assign wr_o.byte_offset = offset_q;
  assign wr_o.pixel_value = value_q;
  assign wr_o.write_bytes = bytes_q;

  a_bytes_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> bytes_q == BYTES_W'(1) || bytes_q == BYTES_W'(2) || bytes_q == BYTES_W'(4))
    else $error("illegal store size");

  a_8bpp_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && bytes_q == BYTES_W'(1) |-> value_q[PIX_W-1:8] == '0)
    else $error("8 bpp value wider than a byte");

  a_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && bytes_q != BYTES_W'(1) |-> !offset_q[0]
      && (bytes_q != BYTES_W'(4) || !offset_q[1]))
    else $error("misaligned store offset");

endmodule

`default_nettype wire

[rtl/glyph_mask_pixel_writer.sv]
// Glyph mask pixel writer: turns a stream of coverage bytes into framebuffer writes.
// Usage:
//   mask_i  - one coverage byte per transaction, row-major over the glyph;
//             glyph_start restarts the column/row counters at the glyph top-left.
//   wr_o    - one write per nonzero byte whose pixel lies on screen: byte offset
//             (y*screen_width+x)*bytes, converted pixel value and store size.
//             Zero bytes, clipped pixels and pixel mode 3 give no transaction.
//   cfg_i   - register writes (index 0..7), always ready; write only while idle.
// Path: a write reaches wr_o from its accepted byte through the input stage register,
// then the output register.
// Throughput: one byte per cycle while wr_o is ready; the counter update and one 12x12 multiply
// each fit in a single stage.
// Reset: counters clear to zero, registers return to their defaults, both
// stages empty. No clearing pass.
// Stall: when wr_o is held off, the output register keeps its write and the
// input stage still takes one more byte if it is empty; mask_i.ready stays low
// while the stage is full, until the output drains.
// Depends on gmpw_pkg, gmpw_if, gmpw_cfg_regs, gmpw_walker, gmpw_pixel_gen.
`default_nettype none

module glyph_mask_pixel_writer import gmpw_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  gmpw_in_if.sink    mask_i,
  gmpw_out_if.source wr_o,
  gmpw_cfg_if.sink   cfg_i
);

  cfg_t cfg;
  stg_t stg;
  logic stg_ready;

  gmpw_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  gmpw_walker u_walker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .mask_i      (mask_i),
    .stg_ready_i (stg_ready),
    .stg_o       (stg)
  );

  gmpw_pixel_gen u_pixel (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .stg_i       (stg),
    .stg_ready_o (stg_ready),
    .wr_o        (wr_o)
  );

endmodule

`default_nettype wire

[dv/testbench.sv]
// Self-checking testbench for glyph_mask_pixel_writer: random and directed mask streams
// and register settings, with an in-bench predictor of the expected framebuffer writes.
// Depends on gmpw_pkg, gmpw_if and the RTL of the block.
`default_nettype none

module testbench;
  import gmpw_pkg::*;

  typedef struct packed {
    logic [COV_W-1:0] coverage;
    logic             start;
  } mask_item_t;

  typedef struct packed {
    logic [OFS_W-1:0]   offset;
    logic [PIX_W-1:0]   value;
    logic [BYTES_W-1:0] nbytes;
  } fb_write_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  gmpw_in_if  mask_if ();
  gmpw_out_if wr_if ();
  gmpw_cfg_if cfg_if ();

  glyph_mask_pixel_writer u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .mask_i (mask_if),
    .wr_o   (wr_if),
    .cfg_i  (cfg_if)
  );

  always #1 clk_i = ~clk_i;

  // predictor copy of the registers and the glyph counters
  logic signed [CFG_W-1:0] m_ox = '0;
  logic signed [CFG_W-1:0] m_oy = '0;
  logic [CFG_W-1:0]        m_gw = RST_GLYPH_W;
  logic [CFG_W-1:0]        m_gh = RST_GLYPH_H;
  logic [CFG_W-1:0]        m_sw = RST_SCREEN_W;
  logic [CFG_W-1:0]        m_sh = RST_SCREEN_H;
  pix_mode_e               m_mode = PIX_565;
  logic [PIX_W-1:0]        m_color = '0;
  int                      glyph_col = 0;
  int                      glyph_row = 0;

  mask_item_t mask_backlog[$];
  fb_write_t  expected_writes[$];
  int         mismatches = 0;
  int         tx_idle;
  int         rx_idle;
  int         hold_reqs = 0;
  int         hold_done = 0;
  int         hold_left = 0;

  function automatic void predict_pixel(mask_item_t it);
    int        gwe;
    int        ghe;
    int        x;
    int        y;
    int        lin;
    int        nb;
    fb_write_t w;
    gwe = (m_gw == 0) ? 1 : ((int'(m_gw) > MAX_DIM) ? MAX_DIM : int'(m_gw));
    ghe = (m_gh == 0) ? 1 : ((int'(m_gh) > MAX_DIM) ? MAX_DIM : int'(m_gh));
    if (it.start) begin
      glyph_col = 0;
      glyph_row = 0;
    end
    x = m_ox + glyph_col;
    y = m_oy + glyph_row;
    if (it.coverage != 0 && m_mode != PIX_NONE && x >= 0 && y >= 0 &&
        x < int'(m_sw) && y < int'(m_sh)) begin
      case (m_mode)
        PIX_8BPP: begin
          nb = 1;
          w.value = {24'h0, m_color[7:0]};
        end
        PIX_565: begin
          nb = 2;
          w.value = {16'h0, m_color[23:19], m_color[15:10], m_color[7:3]};
        end
        default: begin
          nb = 4;
          w.value = m_color;
        end
      endcase
      lin = (y * int'(m_sw) + x) * nb;
      w.offset = lin[OFS_W-1:0];
      w.nbytes = BYTES_W'(nb);
      expected_writes.push_back(w);
    end
    glyph_col++;
    if (glyph_col >= gwe) begin
      glyph_col = 0;
      glyph_row++;
      if (glyph_row >= ghe) begin
        glyph_row = 0;
      end
    end
  endfunction

  // mask stream driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (mask_if.valid && mask_if.ready) begin
        predict_pixel(mask_backlog.pop_front());
      end
      if (!(mask_if.valid && !mask_if.ready)) begin
        if (mask_backlog.size() != 0 && $urandom_range(99) >= tx_idle) begin
          mask_if.valid       <= 1'b1;
          mask_if.coverage    <= mask_backlog[0].coverage;
          mask_if.glyph_start <= mask_backlog[0].start;
        end else begin
          mask_if.valid <= 1'b0;
        end
      end
    end
  end

  // write port backpressure, with long hold-offs on request
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        wr_if.ready <= 1'b0;
      end else if (hold_done != hold_reqs) begin
        hold_done = hold_done + 1;
        hold_left = 80;
        wr_if.ready <= 1'b0;
      end else begin
        wr_if.ready <= ($urandom_range(99) >= rx_idle);
      end
    end
  end

  // write port checker
  always @(posedge clk_i) begin
    fb_write_t e;
    if (rst_ni && wr_if.valid && wr_if.ready) begin
      if (expected_writes.size() == 0) begin
        mismatches++;
        if (mismatches < 200) begin
          $display("%0t unexpected write: expected none, actual offset %h value %h bytes %0d",
                   $time, wr_if.byte_offset, wr_if.pixel_value, wr_if.write_bytes);
        end
      end else begin
        e = expected_writes.pop_front();
        if (e.offset !== wr_if.byte_offset) begin
          mismatches++;
          if (mismatches < 200) begin
            $display("%0t byte_offset: expected %h actual %h", $time, e.offset,
                     wr_if.byte_offset);
          end
        end
        if (e.value !== wr_if.pixel_value) begin
          mismatches++;
          if (mismatches < 200) begin
            $display("%0t pixel_value: expected %h actual %h", $time, e.value,
                     wr_if.pixel_value);
          end
        end
        if (e.nbytes !== wr_if.write_bytes) begin
          mismatches++;
          if (mismatches < 200) begin
            $display("%0t write_bytes: expected %0d actual %0d", $time, e.nbytes,
                     wr_if.write_bytes);
          end
        end
      end
    end
  end

  task automatic drain(int tail);
    do @(posedge clk_i); while (mask_backlog.size() != 0 || expected_writes.size() != 0);
    repeat (tail) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_W-1:0] v12, logic [PIX_W-1:0] full);
    logic [PIX_W-1:0] data;
    data = $urandom;
    data[CFG_W-1:0] = v12;
    if (idx == CFG_DRAW_COLOR) begin
      data = full;
    end
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      CFG_ORIGIN_X:      m_ox = data[CFG_W-1:0];
      CFG_ORIGIN_Y:      m_oy = data[CFG_W-1:0];
      CFG_GLYPH_WIDTH:   m_gw = data[CFG_W-1:0];
      CFG_GLYPH_HEIGHT:  m_gh = data[CFG_W-1:0];
      CFG_SCREEN_WIDTH:  m_sw = data[CFG_W-1:0];
      CFG_SCREEN_HEIGHT: m_sh = data[CFG_W-1:0];
      CFG_PIXEL_MODE:    m_mode = pix_mode_e'(data[1:0]);
      default:           m_color = data;
    endcase
  endtask

  task automatic set_cfg(int ox, int oy, int gw, int gh, int sw, int sh, pix_mode_e mode,
                         logic [PIX_W-1:0] color);
    drain(4);
    write_reg(CFG_ORIGIN_X, ox[CFG_W-1:0], '0);
    write_reg(CFG_ORIGIN_Y, oy[CFG_W-1:0], '0);
    write_reg(CFG_GLYPH_WIDTH, gw[CFG_W-1:0], '0);
    write_reg(CFG_GLYPH_HEIGHT, gh[CFG_W-1:0], '0);
    write_reg(CFG_SCREEN_WIDTH, sw[CFG_W-1:0], '0);
    write_reg(CFG_SCREEN_HEIGHT, sh[CFG_W-1:0], '0);
    write_reg(CFG_PIXEL_MODE, CFG_W'(mode), '0);
    write_reg(CFG_DRAW_COLOR, '0, color);
    cfg_if.valid <= 1'b0;
  endtask

  function automatic void push_mask(int cov, bit start);
    mask_item_t it;
    it.coverage = cov[COV_W-1:0];
    it.start    = start;
    mask_backlog.push_back(it);
  endfunction

  function automatic int rand_cov();
    int pick;
    pick = $urandom_range(19);
    if (pick < 6) begin
      return 0;
    end else if (pick < 9) begin
      return 8'hff;
    end
    return $urandom_range(1, 255);
  endfunction

  function automatic int rand_dim(int top);
    int pick;
    pick = $urandom_range(9);
    if (pick == 0) begin
      return 0;
    end else if (pick == 1) begin
      return $urandom_range(2048, 4095);
    end
    return $urandom_range(1, top);
  endfunction

  function automatic int rand_screen();
    int pick;
    pick = $urandom_range(9);
    if (pick == 0) begin
      return 0;
    end else if (pick == 1) begin
      return 4095;
    end else if (pick == 2) begin
      return $urandom_range(1, 4095);
    end
    return $urandom_range(1, 48);
  endfunction

  function automatic int rand_origin();
    int pick;
    pick = $urandom_range(9);
    if (pick == 0) begin
      return -2048;
    end else if (pick == 1) begin
      return 2047;
    end else if (pick == 2) begin
      return $urandom_range(0, 4095);
    end
    return int'($urandom_range(0, 72)) - 24;
  endfunction

  initial begin
    int               n;
    int               pick;
    logic [PIX_W-1:0] color;
    mask_if.valid       = 1'b0;
    mask_if.coverage    = '0;
    mask_if.glyph_start = 1'b0;
    wr_if.ready         = 1'b0;
    cfg_if.valid        = 1'b0;
    cfg_if.index        = CFG_ORIGIN_X;
    cfg_if.data         = '0;
    rst_ni              = 1'b0;
    tx_idle             = 31;
    rx_idle             = 78;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // defaults after reset: 1x1 glyph at the origin
    push_mask(8'hff, 1'b1);
    push_mask(8'h00, 1'b0);
    push_mask(8'h01, 1'b0);

    // clipping on all four screen edges, then a wrap back to the top-left
    set_cfg(-1, -1, 4, 3, 2, 1, PIX_565, 32'h00ff_ffff);
    for (int i = 0; i < 13; i++) begin
      push_mask(8'hff, i == 0);
    end

    // far corner, offset wraps past 24 bits
    set_cfg(2047, 2047, 2, 2, 4095, 4095, PIX_32BPP, 32'ha5c3_0f96);
    for (int i = 0; i < 4; i++) begin
      push_mask(8'h80, i == 0);
    end

    // zero screen width, unused pixel mode, zero glyph size
    set_cfg(0, 0, 3, 1, 0, 480, PIX_8BPP, 32'h1234_5678);
    push_mask(8'hff, 1'b1);
    push_mask(8'h7f, 1'b0);
    set_cfg(0, 0, 3, 1, 800, 480, PIX_NONE, 32'hffff_ffff);
    push_mask(8'hff, 1'b1);
    push_mask(8'h55, 1'b0);
    set_cfg(5, 7, 0, 0, 10, 10, PIX_8BPP, 32'hffff_ff7e);
    push_mask(8'hff, 1'b0);
    push_mask(8'haa, 1'b1);
    push_mask(8'h01, 1'b0);

    for (int p = 0; p < 15; p++) begin
      if (p == 5) begin
        tx_idle = 78;
        rx_idle = 31;
      end else if (p == 10) begin
        tx_idle = 0;
        rx_idle = 0;
      end
      pick = $urandom_range(9);
      color = (pick == 0) ? 32'h0 : ((pick == 1) ? 32'hffff_ffff : 32'($urandom));
      set_cfg(rand_origin(), rand_origin(), rand_dim(24), rand_dim(8), rand_screen(),
              rand_screen(), pix_mode_e'($urandom_range(3)), color);
      n = $urandom_range(44, 128);
      for (int i = 0; i < n; i++) begin
        push_mask(rand_cov(), i == 0 || $urandom_range(31) == 0);
      end
      if (p == 1 || p == 7 || p == 12) begin
        hold_reqs++;
      end
    end

    drain(10);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
rtl/gmpw_pkg.sv
rtl/gmpw_if.sv
rtl/gmpw_cfg_regs.sv
rtl/gmpw_walker.sv
rtl/gmpw_pixel_gen.sv
rtl/glyph_mask_pixel_writer.sv
dv/testbench.sv
